@@ rtl/hq_pkg.sv @@
`default_nettype none

package hq_pkg;

    localparam int KEY_W = 32;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } hq_cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } hq_status_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic up_chk;
        logic up_cmp;
        logic dn_load;
        logic dn_chk;
        logic dn_cmp;
        logic out_load;
    } hq_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic ins_ok;
        logic rem_ok;
        logic at_root;
        logic up_swap;
        logic dn_leaf;
        logic dn_swap;
    } hq_sts_t;

endpackage

`default_nettype wire

@@ rtl/hq_ctrl.sv @@
`default_nettype none

module hq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  hq_pkg::hq_sts_t sts,
    output hq_pkg::hq_ctl_t ctl
);
    import hq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_UP_CHK  = 8'b0000_0010,
        S_UP_CMP  = 8'b0000_0100,
        S_DN_LOAD = 8'b0000_1000,
        S_DN_CHK  = 8'b0001_0000,
        S_DN_CMP  = 8'b0010_0000,
        S_FIN     = 8'b0100_0000,
        S_SPARE   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.accept = 1'b1;
                    if (sts.ins_ok)
                        state_next = S_UP_CHK;
                    else if (sts.rem_ok)
                        state_next = S_DN_LOAD;
                    else
                        state_next = S_FIN;
                end
            end
            S_UP_CHK:
            begin
                ctl.up_chk = 1'b1;
                state_next = sts.at_root ? S_FIN : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                ctl.up_cmp = 1'b1;
                state_next = sts.up_swap ? S_UP_CHK : S_FIN;
            end
            S_DN_LOAD:
            begin
                ctl.dn_load = 1'b1;
                state_next  = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                ctl.dn_chk = 1'b1;
                state_next = sts.dn_leaf ? S_FIN : S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ctl.dn_cmp = 1'b1;
                state_next = sts.dn_swap ? S_DN_CHK : S_FIN;
            end
            S_FIN:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/hq_datapath.sv @@
`default_nettype none

module hq_datapath #(
    parameter int CAPACITY = 64,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hq_pkg::hq_ctl_t                 ctl,
    output hq_pkg::hq_sts_t                 sts,
    input  logic                            cmd,
    input  logic signed [hq_pkg::KEY_W-1:0] value,
    output logic signed [hq_pkg::KEY_W-1:0] top_value,
    output logic [CW-1:0]                   count,
    output logic [1:0]                      status
);
    import hq_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CIW = AW + 2;

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           pos_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;
    logic signed [KEY_W-1:0] top_reg;
    hq_status_t              st_reg;
    hq_status_t              st_next;

    logic signed [KEY_W-1:0] rd_a_q;
    logic signed [KEY_W-1:0] rd_b_q;
    logic [AW-1:0]           rd_addr_a;
    logic [AW-1:0]           rd_addr_b;
    logic                    wr_en;
    logic signed [KEY_W-1:0] wr_data;

    logic signed [KEY_W-1:0] out_top_reg;
    logic [CW-1:0]           out_count_reg;
    hq_status_t              out_status_reg;

    logic                    full;
    logic                    empty;
    logic [CW-1:0]           cnt_m1;
    logic [AW-1:0]           pos_m1;
    logic [AW-1:0]           parent;
    logic [CIW-1:0]          left_w;
    logic [CIW-1:0]          right_w;
    logic [CIW-1:0]          count_w;
    logic                    right_ok;
    logic                    lgt;
    logic                    rgt;
    logic signed [KEY_W-1:0] child_val;
    logic [AW-1:0]           child_idx;

    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign cnt_m1  = count_reg - CW'(1);
    assign pos_m1  = pos_reg - AW'(1);
    assign parent  = pos_m1 >> 1;
    assign left_w  = {1'b0, pos_reg, 1'b1};
    assign right_w = left_w + CIW'(1);
    assign count_w = CIW'(count_reg);

    assign right_ok  = (right_w < count_w);
    assign lgt       = (rd_a_q > key_reg);
    assign rgt       = right_ok && (rd_b_q > (lgt ? rd_a_q : key_reg));
    assign child_val = rgt ? rd_b_q : rd_a_q;
    assign child_idx = rgt ? right_w[AW-1:0] : left_w[AW-1:0];

    always_comb
    begin
        sts         = '0;
        sts.ins_ok  = (cmd == CMD_INSERT) && !full;
        sts.rem_ok  = (cmd == CMD_REMOVE) && !empty;
        sts.at_root = (pos_reg == '0);
        sts.up_swap = (key_reg > rd_a_q);
        sts.dn_leaf = (left_w >= count_w);
        sts.dn_swap = lgt || rgt;
    end

    // read address select: last entry on remove, parent on sift-up, children on sift-down
    always_comb
    begin
        rd_addr_a = left_w[AW-1:0];
        rd_addr_b = right_w[AW-1:0];
        if (ctl.accept)
            rd_addr_a = cnt_m1[AW-1:0];
        else if (ctl.up_chk)
            rd_addr_a = parent;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = key_reg;
        if (ctl.up_chk && sts.at_root)
            wr_en = 1'b1;
        if (ctl.up_cmp)
        begin
            wr_en = 1'b1;
            if (sts.up_swap)
                wr_data = rd_a_q;
        end
        if (ctl.dn_chk && sts.dn_leaf)
            wr_en = 1'b1;
        if (ctl.dn_cmp)
        begin
            wr_en = 1'b1;
            if (sts.dn_swap)
                wr_data = child_val;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        st_next    = st_reg;
        if (ctl.accept)
        begin
            st_next = ST_OK;
            if (cmd == CMD_INSERT)
            begin
                if (full)
                    st_next = ST_FULL;
                else
                begin
                    count_next = count_reg + CW'(1);
                    pos_next   = count_reg[AW-1:0];
                    key_next   = value;
                end
            end
            else
            begin
                if (empty)
                    st_next = ST_EMPTY;
                else
                begin
                    count_next = cnt_m1;
                    pos_next   = '0;
                end
            end
        end
        if (ctl.dn_load)
            key_next = rd_a_q;
        if (ctl.up_cmp && sts.up_swap)
            pos_next = parent;
        if (ctl.dn_cmp && sts.dn_swap)
            pos_next = child_idx;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[pos_reg] <= wr_data;
        rd_a_q <= mem[rd_addr_a];
        rd_b_q <= mem[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        st_reg  <= st_next;
        // any write to the root is the final root value
        if (wr_en && (pos_reg == '0))
            top_reg <= wr_data;
        if (ctl.out_load)
        begin
            out_top_reg    <= empty ? '0 : top_reg;
            out_count_reg  <= count_reg;
            out_status_reg <= st_reg;
        end
    end

    assign top_value = out_top_reg;
    assign count     = out_count_reg;
    assign status    = out_status_reg;

endmodule

`default_nettype wire

@@ rtl/binary_max_heap_queue_top.sv @@
// Binary max-heap priority queue of signed 32-bit keys, CAPACITY entries.
// Input channel (in_valid/in_ready): cmd selects insert (value is the key)
// or remove-max. Output channel (out_valid/out_ready): one transaction per
// input transaction, in order, carrying the root key after the operation
// (zero when empty), the entry count and a status (ok, insert dropped
// because full, remove on empty).
// One operation runs at a time. An insert starts at the new last slot and
// climbs: each level reads the parent, then compares and writes, until the
// key reaches the root or stops climbing. A remove takes the last entry as
// the key at the root and sinks it: each level reads both children, then
// compares and writes, until a leaf or no larger child. A dropped insert or
// an empty remove goes straight to the result. Each level's read is a
// registered read of the two-read-port heap memory. in_ready returns in the
// cycle after the result is loaded.
// If the receiver stalls and the output register is still full when the
// next result is done, the block holds until out_ready frees it.
// Reset empties the queue at once; memory contents need no clearing.
`default_nettype none

module binary_max_heap_queue_top #(
    parameter int CAPACITY = 64,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic signed [hq_pkg::KEY_W-1:0] value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [hq_pkg::KEY_W-1:0] top_value,
    output logic [CW-1:0]                   count,
    output logic [1:0]                      status
);
    import hq_pkg::*;

    hq_ctl_t ctl;
    hq_sts_t sts;

    hq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    hq_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .cmd       (cmd),
        .value     (value),
        .top_value (top_value),
        .count     (count),
        .status    (status)
    );

endmodule

`default_nettype wire

@@ rtl/hq_checker.sv @@
`default_nettype none

module hq_checker #(
    parameter int CAPACITY = 64,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic signed [hq_pkg::KEY_W-1:0] top_value,
    input wire logic [CW-1:0]                   count,
    input wire logic [1:0]                      status
);
    import hq_pkg::*;

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(top_value)
            && $stable(count) && $stable(status))
        else $error("result changed while stalled");

    // one operation at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on back-to-back cycles");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> (count == CW'(CAPACITY)))
        else $error("full drop reported with free slots");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> (count == '0) && (top_value == '0))
        else $error("empty remove reported with entries");

    a_zero_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (count == '0) |-> (top_value == '0))
        else $error("empty queue reported a nonzero maximum");

endmodule

bind binary_max_heap_queue_top hq_checker #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
) u_hq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .top_value (top_value),
    .count     (count),
    .status    (status)
);

`default_nettype wire
